>>> hw/rtl/stable_priority_queue_defines.svh
// Assertion macros shared by the stable priority queue RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

>>> hw/rtl/spq_pkg.sv
// Package for the stable priority queue: default sizes, codes, FSM state
// and the command struct between controller and datapath. No dependencies.
package spq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT   = 16;
   localparam int PRIORITY_BITS_DEFAULT = 4;
   localparam int ID_BITS_DEFAULT       = 16;
   localparam int STATUS_BITS           = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;   // capture the accepted request
      logic exec;   // update the slots and load the result register
   } cmd_type;

endpackage

>>> hw/rtl/spq_datapath.sv
// Datapath of the stable priority queue: request capture, a row of slot
// registers that insert or shift in one step, entry count and result register.
// Depends on spq_pkg.
module spq_datapath #(
   parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int ID_BITS       = spq_pkg::ID_BITS_DEFAULT,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cmd_type         cmd,
   input  spq_pkg::req_kind_type    req_kind,
   input  logic [ID_BITS-1:0]       req_id,
   input  logic [PRIORITY_BITS-1:0] req_priority,
   output spq_pkg::status_type      status,
   output logic [ID_BITS-1:0]       served_id,
   output logic [PRIORITY_BITS-1:0] served_priority,
   output logic [CNT_W-1:0]         fill_level
);

   spq_pkg::req_kind_type    kind_ff;
   logic [ID_BITS-1:0]       new_id_ff;
   logic [PRIORITY_BITS-1:0] new_pri_ff;

   logic [ID_BITS-1:0]       id_ff  [QUEUE_DEPTH];
   logic [ID_BITS-1:0]       id_in  [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] pri_ff [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] pri_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   keep;

   logic [CNT_W-1:0] count_ff, count_in;

   spq_pkg::status_type      status_ff, status_in;
   logic [ID_BITS-1:0]       sid_ff, sid_in;
   logic [PRIORITY_BITS-1:0] spri_ff, spri_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;

   logic is_full, is_empty;

   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // Slots are sorted, so keep is a run of ones from slot 0: a slot holds
   // while its entry ranks at or before the new one.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (count_ff > CNT_W'(i)) && (pri_ff[i] <= new_pri_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         id_in[i]  = id_ff[i];
         pri_in[i] = pri_ff[i];
         if (kind_ff == spq_pkg::REQ_ENQUEUE) begin
            if (!keep[i]) begin
               if (i == 0) begin
                  id_in[i]  = new_id_ff;
                  pri_in[i] = new_pri_ff;
               end else if (keep[i-1]) begin
                  id_in[i]  = new_id_ff;
                  pri_in[i] = new_pri_ff;
               end else begin
                  id_in[i]  = id_ff[i-1];
                  pri_in[i] = pri_ff[i-1];
               end
            end
         end else if (i < QUEUE_DEPTH - 1) begin
            id_in[i]  = id_ff[i+1];
            pri_in[i] = pri_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::STATUS_DONE;
      sid_in    = '0;
      spri_in   = '0;
      if (kind_ff == spq_pkg::REQ_ENQUEUE) begin
         if (is_full) begin
            status_in = spq_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            count_in = count_ff - CNT_W'(1);
            sid_in   = id_ff[0];
            spri_in  = pri_ff[0];
         end
      end
      fill_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         new_id_ff  <= req_id;
         new_pri_ff <= req_priority;
      end
   end

   // full/empty requests leave the slots alone
   always_ff @(posedge clock) begin
      if (cmd.exec && !(kind_ff == spq_pkg::REQ_ENQUEUE ? is_full : is_empty)) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            id_ff[i]  <= id_in[i];
            pri_ff[i] <= pri_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         sid_ff    <= sid_in;
         spri_ff   <= spri_in;
         fill_ff   <= fill_in;
      end
   end

   assign status          = status_ff;
   assign served_id       = sid_ff;
   assign served_priority = spri_ff;
   assign fill_level      = fill_ff;

endmodule

>>> hw/rtl/spq_controller.sv
// Controller of the stable priority queue: accept/execute sequencing and the
// result valid flag. Depends on spq_pkg and stable_priority_queue_defines.svh.
`include "stable_priority_queue_defines.svh"

module spq_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output spq_pkg::cmd_type cmd
);

   spq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = spq_pkg::ST_EXEC;
         end
         spq_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) state_in = spq_pkg::ST_IDLE;
         end
         default: state_in = spq_pkg::ST_IDLE;
      endcase
   end

   // outputs; execution waits until the result register is free
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         spq_pkg::ST_EXEC: begin
            cmd.exec = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `SPQ_ASSERT_NEXT(a_exec_gives_rsp, cmd.exec, rsp_tvalid)
   `SPQ_ASSERT_NEXT(a_load_then_busy, cmd.load, !req_tready && !cmd.load)
   `SPQ_ASSERT_NOW(a_no_exec_over_pending, rsp_tvalid && !rsp_tready, !cmd.exec)

endmodule

>>> hw/rtl/stable_priority_queue.sv
// Stable priority queue: a transferred request is captured in the request registers,
// then the execute step inserts or shifts the whole slot row at once and loads the
// result register. The controller's capture/execute sequence takes no new request
// until the last one has executed; a held result stalls the execute step until it
// is taken. Synchronous reset empties the queue and clears the handshake state; slot
// contents are undefined until written.
module stable_priority_queue #(
   parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int ID_BITS       = spq_pkg::ID_BITS_DEFAULT,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
   localparam int IN_W         = ID_BITS + PRIORITY_BITS,
   localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
   localparam int OUT_W        = spq_pkg::STATUS_BITS + ID_BITS + PRIORITY_BITS + CNT_W,
   localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_TDATA_W-1:0]  req_tdata,   // item_id, priority_req, zero pad
   input  logic                   req_tuser,   // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata    // status, served_id, served_priority,
                                               // fill_level, zero pad
);

   spq_pkg::cmd_type         cmd;
   spq_pkg::status_type      status;
   logic [ID_BITS-1:0]       served_id;
   logic [PRIORITY_BITS-1:0] served_priority;
   logic [CNT_W-1:0]         fill_level;

   spq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .ID_BITS       (ID_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (spq_pkg::req_kind_type'(req_tuser)),
      .req_id          (req_tdata[ID_BITS-1:0]),
      .req_priority    (req_tdata[IN_W-1:ID_BITS]),
      .status          (status),
      .served_id       (served_id),
      .served_priority (served_priority),
      .fill_level      (fill_level)
   );

   assign rsp_tdata = OUT_TDATA_W'({fill_level, served_priority, served_id, status});

endmodule

>>> bench/stable_priority_queue_check.sv
// Checker for the stable priority queue: watches both stream channels, keeps
// its own sorted copy of the queue and compares every result. Uses spq_pkg.
`timescale 1ns / 100ps

module stable_priority_queue_check
   import spq_pkg::*;
#(
   parameter int DEPTH  = QUEUE_DEPTH_DEFAULT,
   parameter int PRI_W  = PRIORITY_BITS_DEFAULT,
   parameter int ID_W   = ID_BITS_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int IN_TW = ((ID_W + PRI_W + 7) / 8) * 8,
   localparam int OUT_TW = ((STATUS_BITS + ID_W + PRI_W + CNT_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [IN_TW-1:0]  req_tdata,   // item_id, priority_req, zero pad
   input  logic              req_tuser,   // req_type
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [OUT_TW-1:0] rsp_tdata,   // status, served_id, served_priority,
                                          // fill_level, zero pad
   output int                errors,
   output int                pending,
   output int                served_count,
   output int                full_hits,
   output int                empty_hits
);

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
   } entry_t;

   typedef struct {
      status_type       status;
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
      logic [CNT_W-1:0] fill;
   } outcome_t;

   entry_t   held_entries[$];
   outcome_t awaited_results[$];

   initial begin
      errors       = 0;
      pending      = 0;
      served_count = 0;
      full_hits    = 0;
      empty_hits   = 0;
   end

   // Apply one request to the local queue and return the result it should give.
   function automatic outcome_t apply_request(req_kind_type kind, logic [ID_W-1:0] id,
                                              logic [PRI_W-1:0] pri);
      outcome_t res;
      entry_t   ent;
      int       pos;
      res.status = STATUS_DONE;
      res.id     = '0;
      res.pri    = '0;
      if (kind == REQ_ENQUEUE) begin
         if (held_entries.size() >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            // goes behind every entry of equal or more urgent priority
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].pri <= pri) pos++;
            ent.id  = id;
            ent.pri = pri;
            held_entries.insert(pos, ent);
         end
      end else begin
         if (held_entries.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            ent     = held_entries.pop_front();
            res.id  = ent.id;
            res.pri = ent.pri;
         end
      end
      res.fill = CNT_W'(held_entries.size());
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      outcome_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected, data %0h",
                        $time, rsp_tdata);
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tdata[STATUS_BITS-1:0]));
               check_field("served_id", 32'(want.id), 32'(rsp_tdata[STATUS_BITS +: ID_W]));
               check_field("served_priority", 32'(want.pri),
                           32'(rsp_tdata[STATUS_BITS + ID_W +: PRI_W]));
               check_field("fill_level", 32'(want.fill),
                           32'(rsp_tdata[STATUS_BITS + ID_W + PRI_W +: CNT_W]));
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_request(req_kind_type'(req_tuser), req_tdata[ID_W-1:0],
                                 req_tdata[ID_W +: PRI_W]);
            case (want.status)
               STATUS_FULL:  full_hits++;
               STATUS_EMPTY: empty_hits++;
               default: if (req_tuser == REQ_DEQUEUE) served_count++;
            endcase
            awaited_results.push_back(want);
         end
      end
      pending <= awaited_results.size();
   end

endmodule

>>> bench/stable_priority_queue_test.sv
// Top of the stable priority queue bench: clock, reset, request stimulus and
// result back-pressure. Needs spq_pkg, the RTL and stable_priority_queue_check.
`timescale 1ns / 100ps

module stable_priority_queue_test;
   import spq_pkg::*;

   localparam int ID_W   = ID_BITS_DEFAULT;
   localparam int PRI_W  = PRIORITY_BITS_DEFAULT;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH_DEFAULT + 1);
   localparam int IN_TW  = ((ID_W + PRI_W + 7) / 8) * 8;
   localparam int OUT_TW = ((STATUS_BITS + ID_W + PRI_W + CNT_W + 7) / 8) * 8;
   localparam int PHASES = 19;
   localparam int PHASE_ITEMS = 100;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [IN_TW-1:0]  req_tdata;    // item_id, priority_req, zero pad
   logic              req_tuser;    // req_type
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [OUT_TW-1:0] rsp_tdata;    // status, served_id, served_priority, fill_level, pad

   int   errors, pending, served_count, full_hits, empty_hits;
   int   sent_count;
   int   stall_left;
   logic quiet;

   stable_priority_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stable_priority_queue_check u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .errors       (errors),
      .pending      (pending),
      .served_count (served_count),
      .full_hits    (full_hits),
      .empty_hits   (empty_hits)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_200_000;
      $display("%0t: timeout, %0d results still outstanding", $time, pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // result-side back-pressure: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one request and hold it until the transfer.
   task automatic send_req(req_kind_type kind, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= IN_TW'({pri, id});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   logic [ID_W-1:0]  fill_ids[16] = '{16'h0001, 16'h0002, 16'h0000, 16'hFFFF, 16'h0003,
                                      16'h0004, 16'h0005, 16'hA5A5, 16'h5A5A, 16'h8000,
                                      16'h0080, 16'h1234, 16'hFEDC, 16'h0006, 16'h0007,
                                      16'h0008};
   logic [PRI_W-1:0] fill_pris[16] = '{4'd5, 4'd5, 4'd0, 4'd15, 4'd5, 4'd0, 4'd15, 4'd7,
                                       4'd7, 4'd3, 4'd3, 4'd10, 4'd1, 4'd5, 4'd15, 4'd0};

   initial begin
      int enq_pct;
      int pri_hi;
      logic [ID_W-1:0] id;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_ENQUEUE;
      rsp_tready = 1'b1;
      quiet      = 1'b0;
      sent_count = 0;
      stall_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dequeue on empty, fill with ties and extremes, refuse on full
      send_req(REQ_DEQUEUE, 16'hFFFF, 4'hF);
      for (int i = 0; i < 16; i++) begin
         send_req(REQ_ENQUEUE, fill_ids[i], fill_pris[i]);
         maybe_idle();
      end
      send_req(REQ_ENQUEUE, 16'hFFFF, 4'd0);
      send_req(REQ_ENQUEUE, 16'h0000, 4'd15);
      for (int i = 0; i < 6; i++) send_req(REQ_DEQUEUE, 16'h0000, 4'd0);

      // random phases with a drifting enqueue bias so the queue swings full/empty
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 2) quiet = 1'b1;
         if (p == PHASES / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         case ($urandom_range(0, 2))
            0:       enq_pct = 20;
            1:       enq_pct = 50;
            default: enq_pct = 80;
         endcase
         // narrow priority range gives long runs of ties
         pri_hi = $urandom_range(0, 1) ? 15 : $urandom_range(0, 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            id = ID_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < enq_pct)
               send_req(REQ_ENQUEUE, id, PRI_W'($urandom_range(0, pri_hi)));
            else
               send_req(REQ_DEQUEUE, id, PRI_W'($urandom_range(0, 15)));
            maybe_idle();
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests: %0d entries served, %0d refused on full,",
               sent_count, served_count, full_hits);
      $display("%0d dequeues on empty, with ties and stalls on both channels.", empty_hits);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0t: %0d mismatches, %0d results missing", $time, errors, pending);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
